>>> src/duplicate_value_reporter_top_macros.svh
// ----------------------------------------------------------------------------
// duplicate_value_reporter_top_macros
// Assertion macros for the duplicate value reporter; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef DUPLICATE_VALUE_REPORTER_TOP_MACROS_SVH
`define DUPLICATE_VALUE_REPORTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// check cons in the same cycle as ante
`define DVR_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// check cons in the cycle after ante
`define DVR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define DVR_ASSERT_SAME(label, clk, rstn, ante, cons)
`define DVR_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

>>> src/dvr_pkg.sv
// ----------------------------------------------------------------------------
// dvr_pkg
// Shared types and constants of the duplicate value reporter.
// ----------------------------------------------------------------------------
`default_nettype none

package dvr_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned CNT_W   = 4;
    localparam int unsigned Q_DEPTH = 2;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             overflow;
        logic             mode;
    } desc_t;

    typedef struct packed {
        logic                     en;
        logic [CNT_W-1:0]         addr;
        logic signed [DATA_W-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic active;
        logic done;
    } back_status_t;

endpackage

`default_nettype wire

>>> src/dvr_front.sv
// ----------------------------------------------------------------------------
// dvr_front
// Load unit: stores list words, counts them and issues one run per list.
// ----------------------------------------------------------------------------
`default_nettype none

module dvr_front #(
    parameter int unsigned MAX_ELEMENTS = 8
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [31:0]            s_tdata,   // [31:0] element_value
    input  wire logic                   s_tlast,   // last_element
    input  wire logic                   report_mode,
    input  wire logic                   q_ready,
    output logic                        q_push,
    output dvr_pkg::desc_t              q_desc,
    input  wire dvr_pkg::back_status_t  back_status,
    output dvr_pkg::mem_wr_t            mem_wr
);
    import dvr_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next, count_after;
    logic             ovf_reg, ovf_next, ovf_after;
    logic             hold_reg, hold_next;
    logic             accept;
    logic             store;

    assign s_tready = !hold_reg && q_ready;
    assign accept   = s_tvalid && s_tready;
    assign store    = count_reg < CNT_W'(MAX_ELEMENTS);

    assign count_after = store ? count_reg + 1'b1 : count_reg;
    assign ovf_after   = ovf_reg | !store;

    assign mem_wr.en   = accept && store;
    assign mem_wr.addr = count_reg;
    assign mem_wr.data = s_tdata;

    assign q_push          = accept && s_tlast;
    assign q_desc.count    = count_after;
    assign q_desc.overflow = ovf_after;
    assign q_desc.mode     = report_mode;

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        hold_next  = hold_reg;
        if (accept) begin
            if (s_tlast) begin
                count_next = '0;
                ovf_next   = 1'b0;
                hold_next  = 1'b1;
            end else begin
                count_next = count_after;
                ovf_next   = ovf_after;
            end
        end
        if (back_status.done) begin
            hold_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            hold_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

`default_nettype wire

>>> src/dvr_queue.sv
// ----------------------------------------------------------------------------
// dvr_queue
// Short run queue between the load unit and the search engine.
// ----------------------------------------------------------------------------
`default_nettype none

module dvr_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  wire dvr_pkg::desc_t  push_desc,
    output logic                 push_ready,
    input  wire logic            pop,
    output logic                 pop_valid,
    output dvr_pkg::desc_t       pop_desc
);
    import dvr_pkg::*;

    localparam int unsigned Q_AW = $clog2(Q_DEPTH);

    desc_t             entry_reg [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_AW:0]     fill_reg, fill_next;
    logic              do_push, do_pop;

    assign push_ready = fill_reg != (Q_AW+1)'(Q_DEPTH);
    assign pop_valid  = fill_reg != '0;
    assign pop_desc   = entry_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        fill_next = fill_reg;
        if (do_push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

>>> src/dvr_back.sv
// ----------------------------------------------------------------------------
// dvr_back
// Search engine: element memory, pairwise compare sequencer, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dvr_back #(
    parameter int unsigned MAX_ELEMENTS = 8
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire dvr_pkg::mem_wr_t   mem_wr,
    input  wire logic               q_valid,
    input  wire dvr_pkg::desc_t     q_desc,
    output logic                    q_pop,
    output dvr_pkg::back_status_t   back_status,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [31:0]             m_tdata,   // [31:0] found_value
    output logic [1:0]              m_tuser,   // [0] value_valid, [1] list_overflow
    output logic                    m_tlast    // end_of_run
);
    import dvr_pkg::*;

    localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_RD_I  = 5'b00010,
        ST_CAP_I = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_CLOSE = 5'b10000
    } back_state_t;

    logic signed [DATA_W-1:0] mem [MAX_ELEMENTS];
    logic signed [DATA_W-1:0] rd_data_reg;
    logic                     rd_en;
    logic [CNT_W-1:0]         rd_addr;

    back_state_t              state_reg, state_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CNT_W-1:0]         i_reg, i_next;
    logic [CNT_W-1:0]         j_reg, j_next;
    logic [CNT_W-1:0]         j_first;
    logic signed [DATA_W-1:0] vi_reg, vi_next;
    logic                     mode_reg, mode_next;
    logic                     ovf_reg, ovf_next;

    logic                     m_valid_reg;
    logic [DATA_W-1:0]        m_data_reg, out_data;
    logic [1:0]               m_user_reg, out_user;
    logic                     m_last_reg, out_last;
    logic                     load_out;
    logic                     emit_ok;
    logic                     equal;
    logic                     last_j;
    logic                     done;

    always_ff @(posedge aclk) begin
        if (mem_wr.en) begin
            mem[mem_wr.addr[AW-1:0]] <= mem_wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr[AW-1:0]];
        end
    end

    assign emit_ok = !m_valid_reg || m_tready;
    assign equal   = rd_data_reg == vi_reg;
    assign last_j  = j_reg == n_reg - 1'b1;
    assign j_first = mode_reg ? '0 : i_reg + 1'b1;

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        vi_next    = vi_reg;
        mode_next  = mode_reg;
        ovf_next   = ovf_reg;
        rd_en      = 1'b0;
        rd_addr    = i_reg;
        q_pop      = 1'b0;
        done       = 1'b0;
        load_out   = 1'b0;
        out_data   = vi_reg;
        out_user   = 2'b01;
        out_last   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    n_next    = q_desc.count;
                    mode_next = q_desc.mode;
                    ovf_next  = q_desc.overflow;
                    i_next    = '0;
                    if (!q_desc.mode && q_desc.count < CNT_W'(2)) begin
                        state_next = ST_CLOSE;
                    end else begin
                        state_next = ST_RD_I;
                    end
                end
            end
            ST_RD_I: begin
                rd_en      = 1'b1;
                rd_addr    = i_reg;
                state_next = ST_CAP_I;
            end
            ST_CAP_I: begin
                vi_next    = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = j_first;
                j_next     = j_first;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (!mode_reg) begin
                    if (!(equal && !emit_ok)) begin
                        load_out = equal;
                        if (last_j) begin
                            i_next = i_reg + 1'b1;
                            if (i_reg + CNT_W'(2) >= n_reg) begin
                                state_next = ST_CLOSE;
                            end else begin
                                state_next = ST_RD_I;
                            end
                        end else begin
                            j_next  = j_reg + 1'b1;
                            rd_en   = 1'b1;
                            rd_addr = j_reg + 1'b1;
                        end
                    end
                end else begin
                    if ((equal && j_reg != i_reg) || (last_j && emit_ok)) begin
                        load_out = !(equal && j_reg != i_reg);
                        i_next   = i_reg + 1'b1;
                        if (i_reg + 1'b1 == n_reg) begin
                            state_next = ST_CLOSE;
                        end else begin
                            state_next = ST_RD_I;
                        end
                    end else if (!last_j) begin
                        j_next  = j_reg + 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = j_reg + 1'b1;
                    end
                end
            end
            ST_CLOSE: begin
                if (emit_ok) begin
                    load_out   = 1'b1;
                    out_data   = '0;
                    out_user   = {ovf_reg, 1'b0};
                    out_last   = 1'b1;
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        vi_reg   <= vi_next;
        mode_reg <= mode_next;
        ovf_reg  <= ovf_next;
        if (load_out) begin
            m_data_reg <= out_data;
            m_user_reg <= out_user;
            m_last_reg <= out_last;
        end
    end

    assign back_status.active = state_reg != ST_IDLE;
    assign back_status.done   = done;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

>>> src/duplicate_value_reporter_top.sv
// ----------------------------------------------------------------------------
// duplicate_value_reporter_top
// Loads a list of signed words and reports equal pairs or unique values.
// ----------------------------------------------------------------------------
// Use: write report_mode on cfg_valid/cfg_data while idle (0 = equal pairs,
// 1 = unique values). Stream list words on the s_ channel, one per cycle;
// s_tlast marks the final word. Words past MAX_ELEMENTS are dropped and the
// closing word reports list_overflow in m_tuser[1].
// After the final word s_tready stays low while the search engine scans its
// element memory: the ST_RD_I and ST_CAP_I states fetch each outer element,
// then the scan makes one compare per cycle through the single registered
// read port unless a result waits on m_tready; one closing word with m_tlast
// high ends the run. Each run passes through the run queue before the scan,
// and each result leaves through the output register on the m_ channel.
// When m_tready is low the result register holds and the scan stalls on the
// next word to emit. Reset clears the count, the run queue and the output
// register; the element memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

`include "duplicate_value_reporter_top_macros.svh"

module duplicate_value_reporter_top #(
    parameter int unsigned MAX_ELEMENTS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] element_value
    input  wire logic        s_tlast,   // last_element
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] found_value
    output logic [1:0]       m_tuser,   // [0] value_valid, [1] list_overflow
    output logic             m_tlast    // end_of_run
);
    import dvr_pkg::*;

    logic         mode_reg;
    logic         q_push, q_ready, q_pop, q_valid;
    desc_t        push_desc, pop_desc;
    mem_wr_t      mem_wr;
    back_status_t back_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= cfg_data;
        end
    end

    dvr_front #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .report_mode (mode_reg),
        .q_ready     (q_ready),
        .q_push      (q_push),
        .q_desc      (push_desc),
        .back_status (back_status),
        .mem_wr      (mem_wr)
    );

    dvr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (push_desc),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_desc   (pop_desc)
    );

    dvr_back #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .mem_wr      (mem_wr),
        .q_valid     (q_valid),
        .q_desc      (pop_desc),
        .q_pop       (q_pop),
        .back_status (back_status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    `DVR_ASSERT_SAME(a_busy_blocks_load, aclk, aresetn, q_valid || back_status.active, !s_tready)
    `DVR_ASSERT_NEXT(a_last_blocks_load, aclk, aresetn, s_tvalid && s_tready && s_tlast, !s_tready)
    `DVR_ASSERT_SAME(a_close_is_empty, aclk, aresetn, m_tvalid && m_tlast, !m_tuser[0] && m_tdata == 32'd0)
    `DVR_ASSERT_SAME(a_value_no_ovf, aclk, aresetn, m_tvalid && !m_tlast, m_tuser[0] && !m_tuser[1])

endmodule

`default_nettype wire
